// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with async reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define BRA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define BRA_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants, status codes and types of the run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int BLOCKS  = 64;
    localparam int IDX_W   = $clog2(BLOCKS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int LEN_W   = 7;
    localparam int START_W = 6;
    localparam int STAT_W  = 2;
    localparam int RUN_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam int IN_TDATA_W   = 16;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_TUSER_W  = STAT_W;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZEROLEN = 2'd3;

    // one memory word per block: occupancy bit plus run length at a start
    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] len;
    } bra_entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        bra_entry_t       wr_data;
    } bra_mem_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } bra_result_t;

endpackage

// ===== rtl/bra_mem.sv =====
// ----------------------------------------------------------------------------
// bra_mem
// Block table memory: one entry per block, registered read, per-entry valid.
// ----------------------------------------------------------------------------
module bra_mem
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bra_pkg::bra_mem_req_t req,
    output bra_pkg::bra_entry_t   rd_data
);

    bra_pkg::bra_entry_t         mem [bra_pkg::BLOCKS];
    bra_pkg::bra_entry_t         rd_data_reg;
    logic                        rd_vld_reg;
    logic [bra_pkg::BLOCKS-1:0]  valid_reg;

    // never-written entries read as free, length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/bra_ctrl.sv =====
// ----------------------------------------------------------------------------
// bra_ctrl
// Sequencer: first-fit scan, run marking, free check and run release.
// ----------------------------------------------------------------------------
module bra_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_action,
    input  logic [bra_pkg::LEN_W-1:0]     in_len,
    input  logic [bra_pkg::START_W-1:0]   in_sb,
    output bra_pkg::bra_mem_req_t         mreq,
    input  bra_pkg::bra_entry_t           rd_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bra_pkg::bra_result_t          res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MARK = 3'd2;
    localparam logic [2:0] S_FCHK = 3'd3;
    localparam logic [2:0] S_FCLR = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    localparam logic [bra_pkg::IDX_W-1:0] LAST_IDX = bra_pkg::IDX_W'(bra_pkg::BLOCKS - 1);

    logic [2:0]                  state_reg,  state_next;
    logic [bra_pkg::LEN_W-1:0]   len_reg,    len_next;
    logic [bra_pkg::CNT_W-1:0]   cnt_reg,    cnt_next;
    logic                        pend_reg,   pend_next;
    logic [bra_pkg::IDX_W-1:0]   chk_reg,    chk_next;
    logic [bra_pkg::RUN_W-1:0]   run_reg,    run_next;
    logic [bra_pkg::IDX_W-1:0]   start_reg,  start_next;
    logic [bra_pkg::IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [bra_pkg::RUN_W-1:0]   remain_reg, remain_next;
    bra_pkg::bra_result_t        res_reg,    res_next;

    logic                        issue;
    logic [bra_pkg::RUN_W-1:0]   run_inc;

    assign run_inc = run_reg + bra_pkg::RUN_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        chk_next    = chk_reg;
        run_next    = run_reg;
        start_next  = start_reg;
        wr_idx_next = wr_idx_reg;
        remain_next = remain_reg;
        res_next    = res_reg;
        mreq        = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        issue       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    len_next = in_len;
                    if (in_action == bra_pkg::ACT_ALLOC)
                    begin
                        if (in_len == '0)
                        begin
                            res_next   = '{bra_pkg::ST_ZEROLEN, '0, '0};
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            run_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (int'(in_sb) >= bra_pkg::BLOCKS)
                    begin
                        res_next   = '{bra_pkg::ST_BADFREE, '0, '0};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = bra_pkg::IDX_W'(in_sb);
                        start_next   = bra_pkg::IDX_W'(in_sb);
                        state_next   = S_FCHK;
                    end
                end
            end

            S_SCAN:
            begin
                // read block cnt, judge block cnt-1 returned this cycle
                issue        = (cnt_reg < bra_pkg::CNT_W'(bra_pkg::BLOCKS));
                mreq.rd_en   = issue;
                mreq.rd_addr = cnt_reg[bra_pkg::IDX_W-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + bra_pkg::CNT_W'(1);
                end
                pend_next = issue;
                chk_next  = cnt_reg[bra_pkg::IDX_W-1:0];
                if (pend_reg)
                begin
                    if (rd_data.used)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = run_inc;
                    end
                    if (!rd_data.used && run_inc == bra_pkg::RUN_W'(len_reg))
                    begin
                        start_next  = bra_pkg::IDX_W'(bra_pkg::CNT_W'(chk_reg)
                                      + bra_pkg::CNT_W'(1) - bra_pkg::CNT_W'(len_reg));
                        wr_idx_next = bra_pkg::IDX_W'(bra_pkg::CNT_W'(chk_reg)
                                      + bra_pkg::CNT_W'(1) - bra_pkg::CNT_W'(len_reg));
                        remain_next = bra_pkg::RUN_W'(len_reg);
                        state_next  = S_MARK;
                    end
                    else if (chk_reg == LAST_IDX)
                    begin
                        res_next   = '{bra_pkg::ST_NOSPACE, '0, '0};
                        state_next = S_RESP;
                    end
                end
            end

            S_MARK:
            begin
                mreq.wr_en        = 1'b1;
                mreq.wr_addr      = wr_idx_reg;
                mreq.wr_data.used = 1'b1;
                mreq.wr_data.len  = (wr_idx_reg == start_reg) ? len_reg : '0;
                wr_idx_next       = wr_idx_reg + bra_pkg::IDX_W'(1);
                remain_next       = remain_reg - bra_pkg::RUN_W'(1);
                if (remain_reg == bra_pkg::RUN_W'(1))
                begin
                    res_next   = '{bra_pkg::ST_OK, bra_pkg::START_W'(start_reg), len_reg};
                    state_next = S_RESP;
                end
            end

            S_FCHK:
            begin
                // recorded length is cleared whatever the outcome
                mreq.wr_en        = 1'b1;
                mreq.wr_addr      = start_reg;
                mreq.wr_data.used = rd_data.used;
                mreq.wr_data.len  = '0;
                if (rd_data.len == '0 || !rd_data.used)
                begin
                    res_next   = '{bra_pkg::ST_BADFREE, '0, '0};
                    state_next = S_RESP;
                end
                else
                begin
                    mreq.wr_data.used = 1'b0;
                    res_next    = '{bra_pkg::ST_OK, bra_pkg::START_W'(start_reg), rd_data.len};
                    remain_next = bra_pkg::RUN_W'(rd_data.len) - bra_pkg::RUN_W'(1);
                    wr_idx_next = start_reg + bra_pkg::IDX_W'(1);
                    if (rd_data.len == bra_pkg::LEN_W'(1) || start_reg == LAST_IDX)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_FCLR;
                    end
                end
            end

            S_FCLR:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = wr_idx_reg;
                mreq.wr_data = '0;
                wr_idx_next  = wr_idx_reg + bra_pkg::IDX_W'(1);
                remain_next  = remain_reg - bra_pkg::RUN_W'(1);
                if (remain_reg == bra_pkg::RUN_W'(1) || wr_idx_reg == LAST_IDX)
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        cnt_reg    <= cnt_next;
        chk_reg    <= chk_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        wr_idx_reg <= wr_idx_next;
        remain_reg <= remain_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/bra_obuf.sv =====
// ----------------------------------------------------------------------------
// bra_obuf
// Output beat register; frees the sequencer while a result waits downstream.
// ----------------------------------------------------------------------------
module bra_obuf
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load_valid,
    output logic                                load_ready,
    input  bra_pkg::bra_result_t                load_data,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bra_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [bra_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    logic                  valid_reg;
    bra_pkg::bra_result_t  data_reg;

    assign load_ready = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_valid && load_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            data_reg <= load_data;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = bra_pkg::OUT_TDATA_W'({data_reg.len, data_reg.start});
    assign m_axis_tuser  = data_reg.status;

endmodule

// ===== rtl/bitmap_run_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// First-fit allocator of contiguous block runs over a per-block memory table.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one request beat: tuser = action (0 alloc, 1 free),
//   tdata = run_length / start_block. Master channel returns exactly one
//   result beat per request: tuser = status, tdata = start / length.
//   One request is in flight at a time; s_axis_tready is high only while the
//   sequencer is idle.
// Sequence (accept to result loaded):
//   zero-length alloc or out-of-range free: the result is loaded directly.
//   alloc: first-fit scan from block 0 to the end block E of the first fit
//     (or to BLOCKS-1 on no space), then one write per granted block.
//   free: read and check of the start block (the check writes the start
//     block), then one write per further released block.
//   Throughput is bound by the one read and one write port of the block
//   table; a request is longest when the whole map is granted in one run.
// Reset: all blocks free, all recorded lengths zero, both channels idle.
// Stall: the result sits in an output register; the sequencer goes back to
//   idle and takes the next request, but holds its next result until the
//   register is drained.
// ----------------------------------------------------------------------------
module bitmap_run_allocator
(
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bra_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [6:0] run_length, [12:7] start_block
    input  logic [bra_pkg::IN_TUSER_W-1:0]      s_axis_tuser,   // [0] action
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bra_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [5:0] granted_start, [12:6] granted_length
    output logic [bra_pkg::OUT_TUSER_W-1:0]     m_axis_tuser    // [1:0] status
);

    bra_pkg::bra_mem_req_t  mreq;
    bra_pkg::bra_entry_t    rd_data;
    bra_pkg::bra_result_t   res;
    logic                   res_valid;
    logic                   res_ready;

    // block table: occupancy bit + recorded run length per block
    bra_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .rd_data (rd_data)
    );

    bra_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .in_len    (s_axis_tdata[bra_pkg::LEN_W-1:0]),
        .in_sb     (s_axis_tdata[bra_pkg::LEN_W +: bra_pkg::START_W]),
        .mreq      (mreq),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    bra_obuf u_obuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (res_valid),
        .load_ready    (res_ready),
        .load_data     (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/bra_checker.sv =====
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks of the run allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bra_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bra_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic [bra_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    logic [bra_pkg::LEN_W-1:0] out_len;

    assign out_len = m_axis_tdata[bra_pkg::START_W +: bra_pkg::LEN_W];

    // stalled result beat holds
    `BRA_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed under stall")

    // one request at a time: no accept on the cycle after an accept
    `BRA_ASSERT(a_single_item, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while busy")

    // error results carry zero start and length
    `BRA_NEVER(a_err_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser != bra_pkg::ST_OK && m_axis_tdata != '0, "error beat with nonzero fields")

    // good results carry a length within the block count
    `BRA_NEVER(a_ok_len, clk, rst_n, m_axis_tvalid && m_axis_tuser == bra_pkg::ST_OK && (out_len == '0 || int'(out_len) > bra_pkg::BLOCKS), "ok beat with bad length")

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
